// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, pre, post, msg)
`endif
`endif

// ===== design/sjet_pkg.sv =====
// ----------------------------------------------------------------------------
// sjet_pkg
// shared types and constants of the EUC-JP / Shift_JIS transcoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sjet_pkg;

    // direction register codes
    localparam logic DIR_EUC_TO_SJIS = 1'b0;
    localparam logic DIR_SJIS_TO_EUC = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] KANA_FIRST  = 8'hA0;
    localparam logic [7:0] KANA_END    = 8'hE0;
    localparam logic [7:0] SS2         = 8'h8E;

    // one complete character handed from front to back
    typedef struct packed {
        logic       dir;
        logic       pair;
        logic [7:0] hi;
        logic [7:0] lo;
        logic       last;
    } char_t;

endpackage

// ===== design/sjet_front.sv =====
// ----------------------------------------------------------------------------
// sjet_front
// direction register, byte classification and lead byte hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sjet_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output sjet_pkg::char_t     push_data,
    input  logic                full
);

    logic       dir_reg;
    logic       dir_next;
    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] lead_byte_reg;
    logic [7:0] lead_byte_next;
    logic       accept;
    logic       single;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (dir_reg == sjet_pkg::DIR_SJIS_TO_EUC)
        begin
            single = (in_byte < sjet_pkg::ASCII_LIMIT) ||
                     ((in_byte >= sjet_pkg::KANA_FIRST) && (in_byte < sjet_pkg::KANA_END));
        end
        else
        begin
            single = (in_byte < sjet_pkg::ASCII_LIMIT);
        end
    end

    always_comb
    begin
        dir_next          = cfg_wr_en ? cfg_wr_data : dir_reg;
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        push              = 1'b0;
        push_data.dir     = dir_reg;
        push_data.pair    = 1'b1;
        push_data.hi      = lead_byte_reg;
        push_data.lo      = in_byte;
        push_data.last    = in_last;
        if (accept)
        begin
            if (lead_pending_reg)
            begin
                push              = 1'b1;
                lead_pending_next = 1'b0;
                lead_byte_next    = 8'h00;
            end
            else if (single)
            begin
                push           = 1'b1;
                push_data.pair = 1'b0;
                push_data.hi   = 8'h00;
            end
            else if (in_last)
            begin
                // lead on the final item pairs with a zero trail
                push         = 1'b1;
                push_data.hi = in_byte;
                push_data.lo = 8'h00;
            end
            else
            begin
                lead_pending_next = 1'b1;
                lead_byte_next    = in_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg          <= sjet_pkg::DIR_EUC_TO_SJIS;
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
        end
        else
        begin
            dir_reg          <= dir_next;
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
        end
    end

endmodule

// ===== design/sjet_fifo.sv =====
// ----------------------------------------------------------------------------
// sjet_fifo
// short character queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sjet_fifo
#(
    parameter int DEPTH = sjet_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sjet_pkg::char_t     push_data,
    output logic                full,
    input  logic                pop,
    output sjet_pkg::char_t     head,
    output logic                head_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sjet_pkg::char_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_fifo_no_overflow, !(push && full && !pop), "push into full queue")
    `ASSERT_ALWAYS(a_fifo_no_underflow, !(pop && !head_valid), "pop from empty queue")
    `ASSERT_ALWAYS(a_fifo_count_range, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ===== design/sjet_back.sv =====
// ----------------------------------------------------------------------------
// sjet_back
// character conversion and byte serializer with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sjet_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  sjet_pkg::char_t     head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    logic       phase_reg;
    logic       phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       out_end_reg;
    logic       out_end_next;

    // conversion results
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;

    // euc to sjis path
    logic [7:0] jh;
    logic [7:0] jl;
    logic [8:0] lo9;
    logic [8:0] d9;
    logic [8:0] s9;
    logic       wrap;
    logic [7:0] e_hi;
    logic [7:0] e_lo;

    // sjis to euc path
    logic [7:0] sh;
    logic [7:0] sd;
    logic [7:0] s_hi;
    logic [7:0] s_lo;
    logic [7:0] s_lo_adj;

    logic load;
    logic last_byte;

    always_comb
    begin
        if (head.hi < 8'hA1)
        begin
            jh = (head.hi >= sjet_pkg::SS2) ? head.hi - sjet_pkg::SS2 : head.hi;
            jl = head.lo;
        end
        else
        begin
            jh = head.hi & 8'h7F;
            jl = head.lo & 8'h7F;
        end
        lo9 = {1'b0, jl} + 9'h01F;
        if (jh[0])
        begin
            e_lo = (lo9 >= 9'h07F) ? lo9[7:0] + 8'h01 : lo9[7:0];
        end
        else
        begin
            e_lo = jl + 8'h7E;
        end
        // row shift; a row below 0x21 wraps far above 0xa0
        wrap = (jh < 8'h21);
        d9   = {1'b0, jh} - 9'h021;
        s9   = {1'b0, d9[8:1]} + 9'h081;
        e_hi = (wrap || (s9 >= 9'h0A0)) ? s9[7:0] + 8'h40 : s9[7:0];

        sh       = (head.hi >= 8'hE0) ? head.hi - 8'h40 : head.hi;
        sd       = sh - 8'h81;
        s_hi     = {sd[6:0], 1'b0} + 8'h21 + ((head.lo >= 8'h9F) ? 8'h01 : 8'h00);
        s_lo_adj = (head.lo >= 8'h7F) ? head.lo - 8'h01 : head.lo;
        s_lo     = (head.lo >= 8'h9F) ? head.lo - 8'h7E : s_lo_adj - 8'h1F;

        if (head.dir == sjet_pkg::DIR_SJIS_TO_EUC)
        begin
            if (!head.pair)
            begin
                two = (head.lo >= 8'hA1);
                b0  = two ? sjet_pkg::SS2 : head.lo;
                b1  = head.lo;
            end
            else
            begin
                two = 1'b1;
                b0  = s_hi | 8'h80;
                b1  = s_lo | 8'h80;
            end
        end
        else
        begin
            two = !((jh == 8'h00) && (jl <= 8'hF0));
            b0  = two ? e_hi : jl;
            b1  = e_lo;
        end
    end

    assign load      = head_valid && (!out_valid_reg || m_tready);
    assign last_byte = !two || phase_reg;
    assign pop       = load && last_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = phase_reg ? b1 : b0;
            out_last_next  = last_byte;
            out_end_next   = last_byte && head.last;
            phase_next     = two && !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    `ASSERT_IMPLIES(a_phase_has_head, phase_reg, head_valid, "second byte pending without a character")
    `ASSERT_IMPLIES(a_two_pop_second, pop && two, phase_reg, "two-byte character popped early")
    `ASSERT_IMPLIES(a_end_is_last, out_valid_reg && out_end_reg, out_last_reg, "stream end off a run end")

endmodule

// ===== design/sjis_eucjp_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// sjis_eucjp_transcoder_top
// byte stream converter between EUC-JP and Shift_JIS
// ----------------------------------------------------------------------------
// the first output byte of a character is registered in the queue and then in the output register
// throughput: one output byte per cycle while m_tready is high, so one item per cycle
// except items that give two bytes; the input stalls while the two-entry queue is full
// a lead byte is held and gives no output on its own unless it is the final item
// reset clears the direction (EUC-JP to Shift_JIS), the held lead, queue and output
`timescale 1ns / 1ps

module sjis_eucjp_transcoder_top
#(
    parameter int QUEUE_DEPTH = sjet_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // direction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] in_byte
    input  logic        s_tlast,        // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // [7:0] out_byte
    output logic        m_tlast,        // run_last
    output logic [0:0]  m_tuser         // [0] stream_end
);

    logic               push;
    sjet_pkg::char_t    push_data;
    logic               full;
    logic               pop;
    sjet_pkg::char_t    head;
    logic               head_valid;
    logic               stream_end;

    sjet_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    sjet_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    sjet_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (stream_end)
    );

    assign m_tuser = stream_end;

endmodule
